// ----- hw/rtl/i2a_pkg.sv -----
// package for the integer to ascii formatter
// item descriptor, back-end states, ascii constants and the digit encode function
// no dependencies
package i2a_pkg;

    localparam int VALUE_W   = 64;
    localparam int WIDTH_W   = 6;
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int DEC_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int BCD_W     = 4 * DEC_DIGITS;
    localparam int NDIG_W    = 5;
    localparam int CONV_CNT_W = 6;
    localparam int DEFAULT_MAX_WIDTH = 63;

    localparam logic [OP_W-1:0] OP_UDEC  = 2'd0;
    localparam logic [OP_W-1:0] OP_SDEC  = 2'd1;
    localparam logic [OP_W-1:0] OP_LHEX  = 2'd2;
    localparam logic [OP_W-1:0] OP_UHEX  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic               hex;
        logic               upper;
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [WIDTH_W-1:0] width;
        logic               zero_fill;
    } t_desc;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CONV,
        B_NORM,
        B_EMIT
    } t_back_state;

    // one digit (0..15) to its ascii code
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ----- hw/rtl/i2a_front.sv -----
// front end: accepts items, classifies mode and sign, takes the magnitude
// registers one descriptor for the queue; uses i2a_pkg
module i2a_front #(
    parameter int MAX_WIDTH = i2a_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [i2a_pkg::OP_W-1:0]    i_op,
    input  logic [i2a_pkg::VALUE_W-1:0] i_value,
    input  logic [i2a_pkg::WIDTH_W-1:0] i_width,
    input  logic                        i_zero_fill,
    output logic                        o_desc_valid,
    output i2a_pkg::t_desc              o_desc,
    input  logic                        i_q_full
);

    localparam logic [i2a_pkg::WIDTH_W-1:0] MAX_W = i2a_pkg::WIDTH_W'(MAX_WIDTH);

    logic           r_valid, n_valid;
    i2a_pkg::t_desc r_desc, n_desc;
    logic           w_accept;

    assign o_full       = r_valid && i_q_full;
    assign w_accept     = i_push && !o_full;
    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

    always_comb begin
        n_valid = w_accept || (r_valid && i_q_full);
        n_desc  = r_desc;
        if (w_accept) begin
            n_desc.hex       = (i_op == i2a_pkg::OP_LHEX) || (i_op == i2a_pkg::OP_UHEX);
            n_desc.upper     = (i_op == i2a_pkg::OP_UHEX);
            n_desc.neg       = (i_op == i2a_pkg::OP_SDEC) && i_value[i2a_pkg::VALUE_W-1];
            n_desc.mag       = n_desc.neg ? (~i_value + 64'd1) : i_value;
            n_desc.width     = (i_width > MAX_W) ? MAX_W : i_width;
            n_desc.zero_fill = i_zero_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_desc <= n_desc;
    end

    property p_neg_not_hex;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && r_desc.neg) |-> !r_desc.hex;
    endproperty
    a_neg_not_hex: assert property (p_neg_not_hex) else $error("hex item marked negative");

    property p_hold_when_blocked;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && i_q_full) |=> (r_valid && $stable(r_desc));
    endproperty
    a_hold_when_blocked: assert property (p_hold_when_blocked) else $error("descriptor lost");

    property p_width_sat;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_valid |-> (r_desc.width <= MAX_W);
    endproperty
    a_width_sat: assert property (p_width_sat) else $error("width above limit");

endmodule

// ----- hw/rtl/i2a_queue.sv -----
// two-entry descriptor queue between front and back end
// uses i2a_pkg for the descriptor type
module i2a_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  i2a_pkg::t_desc i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output i2a_pkg::t_desc o_rdata
);

    i2a_pkg::t_desc r_mem [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_count;
    logic           w_wr, w_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_count <= 2'd2;
    endproperty
    a_count_range: assert property (p_count_range) else $error("queue count out of range");

    property p_ptr_match;
        @(posedge i_clk) disable iff (!i_rst_n)
            ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wptr == r_rptr);
    endproperty
    a_ptr_match: assert property (p_ptr_match) else $error("queue pointers disagree with count");

    property p_ptr_differ;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_count == 2'd1) |-> (r_wptr != r_rptr);
    endproperty
    a_ptr_differ: assert property (p_ptr_differ) else $error("queue pointers equal at one entry");

endmodule

// ----- hw/rtl/i2a_back.sv -----
// back end: binary to bcd by shift-add-3, leading zero strip, character emission
// holds the result register; uses i2a_pkg
module i2a_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  i2a_pkg::t_desc              i_q_data,
    output logic                        o_q_rd,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [i2a_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last
);

    localparam int BW = i2a_pkg::BCD_W;
    localparam int WW = i2a_pkg::WIDTH_W;
    localparam int NW = i2a_pkg::NDIG_W;

    i2a_pkg::t_back_state r_state, n_state;
    logic [i2a_pkg::VALUE_W-1:0]  r_mag, n_mag;
    logic [BW-1:0]                r_bcd, n_bcd;
    logic [i2a_pkg::CONV_CNT_W-1:0] r_cnt, n_cnt;
    logic [NW-1:0]                r_ndig, n_ndig;
    logic                         r_neg, n_neg;
    logic                         r_upper, n_upper;
    logic                         r_zfill, n_zfill;
    logic [WW-1:0]                r_width, n_width;
    logic [WW-1:0]                r_fill, n_fill;
    logic [WW-1:0]                r_rem, n_rem;
    logic                         r_ovalid, n_ovalid;
    logic [i2a_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                         r_last, n_last;

    logic [BW-1:0] w_adj;
    logic [WW-1:0] w_body;
    logic          w_slot;

    assign o_empty     = !r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign w_slot      = !r_ovalid || i_pop;
    assign w_body      = WW'(r_ndig) + WW'(r_neg);

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < i2a_pkg::DEC_DIGITS; k++) begin
            w_adj[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ? (r_bcd[k*4 +: 4] + 4'd3)
                                                         : r_bcd[k*4 +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_ndig   = r_ndig;
        n_neg    = r_neg;
        n_upper  = r_upper;
        n_zfill  = r_zfill;
        n_width  = r_width;
        n_fill   = r_fill;
        n_rem    = r_rem;
        n_ovalid = r_ovalid && !i_pop;
        n_char   = r_char;
        n_last   = r_last;
        o_q_rd   = 1'b0;
        unique case (r_state)
            i2a_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd  = 1'b1;
                    n_neg   = i_q_data.neg;
                    n_upper = i_q_data.upper;
                    n_zfill = i_q_data.zero_fill;
                    n_width = i_q_data.width;
                    n_mag   = i_q_data.mag;
                    if (i_q_data.hex) begin
                        n_bcd   = {i_q_data.mag, {(BW - i2a_pkg::VALUE_W){1'b0}}};
                        n_ndig  = NW'(i2a_pkg::HEX_DIGITS);
                        n_state = i2a_pkg::B_NORM;
                    end else begin
                        n_bcd   = '0;
                        n_ndig  = NW'(i2a_pkg::DEC_DIGITS);
                        n_cnt   = '1;
                        n_state = i2a_pkg::B_CONV;
                    end
                end
            end
            i2a_pkg::B_CONV: begin
                n_bcd = {w_adj[BW-2:0], r_mag[i2a_pkg::VALUE_W-1]};
                n_mag = {r_mag[i2a_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = i2a_pkg::B_NORM;
                end
            end
            i2a_pkg::B_NORM: begin
                // strip one leading zero digit a cycle, keep at least one
                if ((r_bcd[BW-1 -: 4] == 4'd0) && (r_ndig > NW'(1))) begin
                    n_bcd  = {r_bcd[BW-5:0], 4'd0};
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_fill  = (r_width > w_body) ? (r_width - w_body) : '0;
                    n_rem   = (r_width > w_body) ? r_width : w_body;
                    n_state = i2a_pkg::B_EMIT;
                end
            end
            i2a_pkg::B_EMIT: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_last   = (r_rem == WW'(1));
                    n_rem    = r_rem - 1'b1;
                    priority if (r_fill != '0) begin
                        n_char = r_zfill ? i2a_pkg::CH_ZERO : i2a_pkg::CH_SPACE;
                        n_fill = r_fill - 1'b1;
                    end else if (r_neg) begin
                        n_char = i2a_pkg::CH_MINUS;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = i2a_pkg::digit_char(r_bcd[BW-1 -: 4], r_upper);
                        n_bcd  = {r_bcd[BW-5:0], 4'd0};
                    end
                    if (r_rem == WW'(1)) begin
                        n_state = i2a_pkg::B_IDLE;
                    end
                end
            end
            default: begin
                n_state = i2a_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2a_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_mag   <= n_mag;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_ndig  <= n_ndig;
        r_neg   <= n_neg;
        r_upper <= n_upper;
        r_zfill <= n_zfill;
        r_width <= n_width;
        r_fill  <= n_fill;
        r_rem   <= n_rem;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    property p_conv_digits;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == i2a_pkg::B_CONV) |-> (r_ndig == NW'(i2a_pkg::DEC_DIGITS));
    endproperty
    a_conv_digits: assert property (p_conv_digits) else $error("digit count wrong in conversion");

    property p_emit_rem;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == i2a_pkg::B_EMIT) |-> (r_rem != '0) && (r_rem > r_fill);
    endproperty
    a_emit_rem: assert property (p_emit_rem) else $error("character count underrun");

    property p_last_ends;
        @(posedge i_clk) disable iff (!i_rst_n)
            ((r_state == i2a_pkg::B_EMIT) && w_slot && (r_rem == WW'(1)))
                |=> (r_state == i2a_pkg::B_IDLE) && r_last && r_ovalid;
    endproperty
    a_last_ends: assert property (p_last_ends) else $error("field did not end with last");

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// integer to ascii formatter, top level
// instantiates i2a_front, i2a_queue and i2a_back; uses i2a_pkg
//
// usage: both sides look like a queue. an item (op, value, width, zero_fill)
// is taken on a clock edge with i_push high and o_full low. characters come
// out one per result: o_character and o_last are valid while o_empty is low
// and move on an edge with i_pop high. o_last marks the final character.
// fill (space or '0') comes first, then '-' for negative signed decimal,
// then the digits with no leading zeros; widths above MAX_WIDTH saturate.
// timing: the front registers an item and writes it into the queue when
// the queue has room. decimal items then pass through the shift-add-3
// converter, one value bit a cycle; hex items skip it. leading zeros are
// stripped at one digit a cycle (up to 19 decimal, 15 hex), then one
// character leaves per cycle while the receiver keeps popping.
// up to three items wait in front of the back end so the host can keep
// pushing. reset clears all control state; no clearing pass is needed.
// a stalled receiver holds the current character and the back end waits;
// o_full rises once the queue and front register are both occupied.
module integer_to_ascii_formatter #(
    parameter int MAX_WIDTH = i2a_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [i2a_pkg::OP_W-1:0]    i_op,
    input  logic [i2a_pkg::VALUE_W-1:0] i_value,
    input  logic [i2a_pkg::WIDTH_W-1:0] i_width,
    input  logic                        i_zero_fill,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [i2a_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last
);

    logic           w_desc_valid;
    i2a_pkg::t_desc w_desc;
    logic           w_q_full;
    logic           w_q_empty;
    logic           w_q_rd;
    i2a_pkg::t_desc w_q_data;

    i2a_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_width      (i_width),
        .i_zero_fill  (i_zero_fill),
        .o_desc_valid (w_desc_valid),
        .o_desc       (w_desc),
        .i_q_full     (w_q_full)
    );

    i2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_desc_valid),
        .i_wdata (w_desc),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_empty (w_q_empty),
        .o_rdata (w_q_data)
    );

    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_data),
        .o_q_rd      (w_q_rd),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ----- tb/tb_top.sv -----
// testbench for integer_to_ascii_formatter: drives format requests and checks each
// character against a behavioral formatter; depends on i2a_pkg and the formatter rtl
module tb_top;
    import i2a_pkg::*;

    localparam int N_RANDOM     = 192;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
        logic               zero_fill;
    } t_field_req;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_field_char;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_push      = 1'b0;
    logic [OP_W-1:0]    i_op        = OP_UDEC;
    logic [VALUE_W-1:0] i_value     = '0;
    logic [WIDTH_W-1:0] i_width     = '0;
    logic               i_zero_fill = 1'b0;
    logic               i_pop       = 1'b0;
    logic               o_full;
    logic               o_empty;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last;

    t_field_req  field_reqs[$];
    t_field_char field_chars[$];
    int          reqs_accepted  = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          push_gap       = 0;
    int          push_burst     = 0;
    int          pop_stall      = 0;
    int          pop_burst      = 0;

    integer_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_width     (i_width),
        .i_zero_fill (i_zero_fill),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // builds the characters of one field and queues them as expected
    function automatic void format_field(input t_field_req req);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  alpha;
        logic [CHAR_W-1:0]  text[$];
        logic               neg;
        int unsigned        base;
        int unsigned        dig;
        int unsigned        body;
        int unsigned        w;
        t_field_char        fc;
        neg   = (req.op == OP_SDEC) && req.value[VALUE_W-1];
        mag   = neg ? -req.value : req.value;
        base  = (req.op == OP_LHEX || req.op == OP_UHEX) ? 16 : 10;
        alpha = (req.op == OP_UHEX) ? CH_UPPER_A : CH_LOWER_A;
        do begin
            dig = int'(mag % base);
            mag = mag / base;
            if (dig < 10)
                text.push_front(CH_ZERO + CHAR_W'(dig));
            else
                text.push_front(alpha + CHAR_W'(dig - 10));
        end while (mag != 0);
        if (neg)
            text.push_front(CH_MINUS);
        body = text.size();
        w = (req.width > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : req.width;
        // fill goes ahead of the sign, zero fill too
        while (body < w) begin
            text.push_front(req.zero_fill ? CH_ZERO : CH_SPACE);
            body++;
        end
        for (int i = 0; i < text.size(); i++) begin
            fc.ch   = text[i];
            fc.last = (i == text.size() - 1);
            field_chars.push_back(fc);
        end
    endfunction

    // mostly no gap, some short, a few long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(80, 10);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        int                 sel;
        v   = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 30)
            v = v >> $urandom_range(63);
        else if (sel < 50)
            v = VALUE_W'($urandom_range(999));
        else if (sel < 60)
            v = -VALUE_W'($urandom_range(1000, 1));
        else if (sel < 65)
            v = {1'b1, {(VALUE_W-1){1'b0}}} + VALUE_W'($urandom_range(3));
        return v;
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input int width, input logic zero_fill);
        t_field_req req;
        req.op        = op;
        req.value     = value;
        req.width     = WIDTH_W'(width);
        req.zero_fill = zero_fill;
        field_reqs.push_back(req);
    endtask

    // driver: an item is taken on an edge with push high and full low
    always @(posedge i_clk) begin : drive_proc
        t_field_req nxt;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                nxt.op        = i_op;
                nxt.value     = i_value;
                nxt.width     = i_width;
                nxt.zero_fill = i_zero_fill;
                format_field(nxt);
                reqs_accepted++;
            end
            if (!(i_push && o_full)) begin
                if (push_gap > 0) begin
                    push_gap--;
                    i_push <= 1'b0;
                end else if (field_reqs.size() > 0) begin
                    nxt = field_reqs.pop_front();
                    i_op        <= nxt.op;
                    i_value     <= nxt.value;
                    i_width     <= nxt.width;
                    i_zero_fill <= nxt.zero_fill;
                    i_push      <= 1'b1;
                    if (push_burst > 0) begin
                        push_burst--;
                        push_gap = 0;
                    end else begin
                        if ($urandom_range(19) == 0)
                            push_burst = $urandom_range(30, 10);
                        push_gap = rand_gap();
                    end
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each popped character against the oldest expectation
    always @(posedge i_clk) begin : check_proc
        t_field_char fc;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (field_chars.size() == 0) begin
                    $error("unexpected character 0x%02h last %0b", o_character, o_last);
                    mismatch_count++;
                end else begin
                    fc = field_chars.pop_front();
                    if (o_character !== fc.ch) begin
                        $error("character: expected 0x%02h, got 0x%02h", fc.ch, o_character);
                        mismatch_count++;
                    end
                    if (o_last !== fc.last) begin
                        $error("last: expected %0b, got %0b", fc.last, o_last);
                        mismatch_count++;
                    end
                end
                if (pop_burst > 0) begin
                    pop_burst--;
                    pop_stall = 0;
                end else begin
                    if ($urandom_range(19) == 0)
                        pop_burst = $urandom_range(60, 20);
                    pop_stall = rand_gap();
                end
            end else if (!i_pop && pop_stall > 0) begin
                pop_stall--;
            end
            i_pop <= (pop_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog_proc
        while (idle_cycles < STALL_LIMIT)
            @(negedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus_proc
        int n_items;
        int w;
        // directed: extremes, every mode, sign corner cases
        add_req(OP_UDEC, 64'd0, 0, 1'b0);
        add_req(OP_UDEC, '1, 0, 1'b0);
        add_req(OP_UDEC, '1, 63, 1'b1);
        add_req(OP_UDEC, 64'd1234567, 3, 1'b1);
        add_req(OP_UDEC, 64'd12345, 63, 1'b0);
        add_req(OP_SDEC, '1, 0, 1'b0);
        add_req(OP_SDEC, {1'b1, 63'd0}, 0, 1'b0);
        add_req(OP_SDEC, {1'b1, 63'd0}, 25, 1'b1);
        add_req(OP_SDEC, -64'd5, 4, 1'b1);
        add_req(OP_SDEC, -64'd5, 4, 1'b0);
        add_req(OP_SDEC, {1'b0, {63{1'b1}}}, 21, 1'b1);
        add_req(OP_SDEC, 64'd0, 1, 1'b1);
        add_req(OP_SDEC, 64'd5, 3, 1'b0);
        add_req(OP_LHEX, 64'hdead_beef_0123_4567, 0, 1'b0);
        add_req(OP_UHEX, 64'h89ab_cdef_fedc_ba98, 18, 1'b1);
        add_req(OP_LHEX, '1, 16, 1'b0);
        add_req(OP_UHEX, '1, 63, 1'b1);
        add_req(OP_LHEX, 64'd0, 63, 1'b0);
        add_req(OP_UHEX, 64'd0, 42, 1'b1);
        add_req(OP_LHEX, {1'b1, 63'd0}, 0, 1'b1);
        for (int i = 0; i < N_RANDOM; i++) begin
            w = ($urandom_range(9) < 7) ? $urandom_range(24) : $urandom_range(63);
            add_req(OP_W'($urandom_range(3)), rand_value(), w, 1'($urandom_range(1)));
        end
        n_items = field_reqs.size();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (reqs_accepted < n_items)
            @(negedge i_clk);
        while (field_chars.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_front.sv
hw/rtl/i2a_queue.sv
hw/rtl/i2a_back.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/tb_top.sv
